// ----- sv/stl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the sorted table key lookup block.
package stl_pkg;

	localparam int STL_DEPTH = 1024;

	localparam int KEY_W      = 64;
	localparam int IDX_IN_W   = 10;
	localparam int COUNT_W    = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = COUNT_W;

	// Operation carried by an input item.
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_PROBE = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FETCH_MODE  = 2'd1;

	typedef struct packed {
		logic                    func;
		logic [IDX_IN_W-1:0]     entry_index;
		logic signed [KEY_W-1:0] key;
		logic                    key_valid;
		logic signed [KEY_W-1:0] payload;
		logic                    payload_valid;
	} stl_req_t;

	typedef struct packed {
		logic                    match_flag;
		logic signed [KEY_W-1:0] lookup_value;
	} stl_rsp_t;

	// One table entry as it sits in memory.
	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic signed [KEY_W-1:0] payload;
		logic                    payload_valid;
	} stl_entry_t;

endpackage

// ----- sv/stl_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response items.
interface stl_req_if import stl_pkg::*; ();
	logic     valid;
	logic     ready;
	stl_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface stl_rsp_if import stl_pkg::*; ();
	logic     valid;
	logic     ready;
	stl_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/stl_table_mem.sv -----
`timescale 1ns / 1ps
// Table entry memory: one write port, one read port with registered read data.
module stl_table_mem import stl_pkg::*; #(
	parameter int TABLE_DEPTH = STL_DEPTH,
	localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  stl_entry_t       wentry,
	input  logic [IDX_W-1:0] raddr,
	output stl_entry_t       rentry
);

	stl_entry_t entry_mem [TABLE_DEPTH];
	stl_entry_t rentry_q;

	always_ff @(posedge clk) begin
		if (we) begin
			entry_mem[waddr] <= wentry;
		end
	end

	always_ff @(posedge clk) begin
		rentry_q <= entry_mem[raddr];
	end

	assign rentry = rentry_q;

endmodule

// ----- sv/stl_search_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for table loads and the lower-bound binary search of probe keys.
module stl_search_ctrl import stl_pkg::*; #(
	parameter int TABLE_DEPTH = STL_DEPTH,
	localparam int IDX_W = $clog2(TABLE_DEPTH),
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [COUNT_W-1:0] table_count,
	input  logic               fetch_mode,
	stl_req_if.sink            req,
	stl_rsp_if.source          rsp,
	output logic               mem_we,
	output logic [IDX_W-1:0]   mem_waddr,
	output stl_entry_t         mem_wentry,
	output logic [IDX_W-1:0]   mem_raddr,
	input  stl_entry_t         mem_rentry
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_SEARCH,
		ST_CHECK
	} state_t;

	localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

	state_t                  state_q;
	logic signed [KEY_W-1:0] key_q;
	logic                    miss_q;
	logic [CNT_W-1:0]        n_q;
	logic [CNT_W-1:0]        lo_q;
	logic [CNT_W-1:0]        hi_q;
	logic [IDX_W-1:0]        mid_q;
	logic                    rsp_valid_q;
	stl_rsp_t                rsp_data_q;

	logic             req_fire;
	logic [31:0]      cnt_wide;
	logic [CNT_W-1:0] n_in;
	logic             rd_less;
	logic [CNT_W-1:0] lo_nx;
	logic [CNT_W-1:0] hi_nx;
	logic [CNT_W-1:0] mid_nx;
	logic             more_steps;
	logic             hit;
	logic             out_free;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;

	// A count above the depth is clamped to the depth.
	assign cnt_wide = 32'(table_count);
	assign n_in     = (cnt_wide > DEPTH32) ? CNT_W'(DEPTH32) : CNT_W'(cnt_wide);

	assign mem_we     = req_fire && (req.data.func == FUNC_LOAD)
		&& (32'(req.data.entry_index) < DEPTH32);
	assign mem_waddr  = IDX_W'(req.data.entry_index);
	assign mem_wentry = '{key: req.data.key, payload: req.data.payload,
		payload_valid: req.data.payload_valid};

	assign rd_less = mem_rentry.key < key_q;

	// One search step per cycle: the key read at mid_q decides the new bounds,
	// and the next midpoint (or, on the last step, the lower bound) goes straight out as the read address.
	always_comb begin
		if (rd_less) begin
			lo_nx = CNT_W'(mid_q) + CNT_W'(1);
			hi_nx = hi_q;
		end else begin
			lo_nx = lo_q;
			hi_nx = CNT_W'(mid_q);
		end
		mid_nx     = lo_nx + ((hi_nx - lo_nx) >> 1);
		more_steps = lo_nx < hi_nx;
	end

	always_comb begin
		case (state_q)
			ST_IDLE:   mem_raddr = '0;
			ST_FIRST:  mem_raddr = IDX_W'(n_q - CNT_W'(1));
			ST_LAST:   mem_raddr = IDX_W'(n_q >> 1);
			ST_SEARCH: mem_raddr = more_steps ? IDX_W'(mid_nx) : IDX_W'(lo_nx);
			ST_CHECK:  mem_raddr = IDX_W'(lo_q);
			default:   mem_raddr = '0;
		endcase
	end

	assign hit      = !miss_q && (lo_q < n_q) && (mem_rentry.key == key_q);
	assign out_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			miss_q      <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			n_q         <= '0;
		end else begin
			if (state_q == ST_CHECK && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire && (req.data.func == FUNC_PROBE)) begin
						key_q  <= req.data.key;
						n_q    <= n_in;
						lo_q   <= '0;
						miss_q <= !req.data.key_valid || (n_in == '0);
						state_q <= (!req.data.key_valid || (n_in == '0)) ? ST_CHECK : ST_FIRST;
					end
				end
				ST_FIRST: begin
					// The first stored key is on the read data now.
					if (key_q < mem_rentry.key) begin
						miss_q  <= 1'b1;
						state_q <= ST_CHECK;
					end else begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					if (key_q < mem_rentry.key || key_q == mem_rentry.key) begin
						lo_q    <= '0;
						hi_q    <= n_q;
						mid_q   <= IDX_W'(n_q >> 1);
						state_q <= ST_SEARCH;
					end else begin
						miss_q  <= 1'b1;
						state_q <= ST_CHECK;
					end
				end
				ST_SEARCH: begin
					lo_q <= lo_nx;
					hi_q <= hi_nx;
					mid_q <= IDX_W'(mid_nx);
					if (!more_steps) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (out_free) begin
						rsp_data_q.match_flag <= hit && (!fetch_mode
							|| mem_rentry.payload_valid);
						rsp_data_q.lookup_value <= (hit && fetch_mode)
							? mem_rentry.payload : '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// The search interval never collapses while a step is still in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (lo_q < hi_q))
		else $error("search interval empty during a search step");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (CNT_W'(mid_q) >= lo_q && CNT_W'(mid_q) < hi_q))
		else $error("search midpoint outside the interval");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (hi_q <= n_q))
		else $error("search upper bound beyond the entries in use");

	// A result is only written into a free output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && rsp_valid_q && !rsp.ready) |=> (state_q == ST_CHECK))
		else $error("probe finished while the output register was occupied");

endmodule

// ----- sv/sorted_table_key_lookup.sv -----
`timescale 1ns / 1ps
// Top level of the sorted table key lookup block with its configuration registers.
//
//   channel   direction  handshake      payload
//   req       in         valid / ready  func, entry_index, key, key_valid, payload,
//                                       payload_valid
//   rsp       out        valid / ready  match_flag, lookup_value
//   cfg       in         cfg_we         cfg_index, cfg_wdata
//
// A load item is written into the entry memory and gives no result. A probe item gives
// its result after bounds reads of the first and last key, one search step per cycle on
// the single read port of the entry memory, and a final compare and payload read. No
// new item is taken while a probe is in progress; the next one can be taken in the same
// cycle as the result appears. A null key, an empty table or a key outside the bounds
// skips the search. Reset clears the registers and control state only; the entry
// memory holds nothing until loaded. A stalled response blocks only the end of the
// next probe.
module sorted_table_key_lookup import stl_pkg::*; #(
	parameter int TABLE_DEPTH = STL_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	stl_req_if.sink               req,
	stl_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	logic [COUNT_W-1:0] table_count_q;
	logic               fetch_mode_q;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	stl_entry_t       mem_wentry;
	logic [IDX_W-1:0] mem_raddr;
	stl_entry_t       mem_rentry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_count_q <= '0;
			fetch_mode_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TABLE_COUNT: table_count_q <= cfg_wdata[COUNT_W-1:0];
				REG_FETCH_MODE:  fetch_mode_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	stl_search_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.table_count(table_count_q),
		.fetch_mode (fetch_mode_q),
		.req        (req),
		.rsp        (rsp),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wentry (mem_wentry),
		.mem_raddr  (mem_raddr),
		.mem_rentry (mem_rentry)
	);

	stl_table_mem #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wentry(mem_wentry),
		.raddr (mem_raddr),
		.rentry(mem_rentry)
	);

endmodule

// ----- verif/sorted_table_key_lookup_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the sorted table key lookup block.
module sorted_table_key_lookup_tb;
	import stl_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_HOLD    = 300;
	localparam int RANDOM_ITEMS = 750;

	localparam logic signed [KEY_W-1:0] KEY_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	// Register indexes that decode to nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef enum int {FILL_WIDE, FILL_CLUSTER, FILL_UNSORTED} fill_style_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	stl_req_if req_ch ();
	stl_rsp_if rsp_ch ();

	sorted_table_key_lookup u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Mirror of the table and registers.
	logic signed [KEY_W-1:0] key_tab [STL_DEPTH];
	logic signed [KEY_W-1:0] pay_tab [STL_DEPTH];
	logic                    pv_tab  [STL_DEPTH];
	logic [COUNT_W-1:0]      tab_count;
	logic                    fetch_on;

	stl_rsp_t lookups_due [$];

	int  mismatches;
	int  loads_sent;
	int  lookups_sent;
	int  lookups_checked;
	int  cycle_cnt;
	int  hold_requests;
	bit  no_gaps;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("sorted_table_key_lookup test failed");
			$finish;
		end
	end

	function automatic logic signed [KEY_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 30);
	endfunction

	// Lower-bound search over the mirrored table.
	function automatic stl_rsp_t predict_lookup(stl_req_t it);
		stl_rsp_t                r;
		logic signed [KEY_W-1:0] k;
		int                      n, lo, hi, mid;
		bit                      found;
		r = '0;
		k = it.key;
		found = 1'b0;
		lo = 0;
		n = (tab_count > STL_DEPTH) ? STL_DEPTH : int'(tab_count);
		if (it.key_valid && n > 0 && !(k < key_tab[0]) && !(key_tab[n-1] < k)) begin
			hi = n;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (key_tab[mid] < k)
					lo = mid + 1;
				else
					hi = mid;
			end
			found = (lo < n) && (key_tab[lo] == k);
		end
		if (found) begin
			if (fetch_on) begin
				r.match_flag = pv_tab[lo];
				r.lookup_value = pay_tab[lo];
			end else begin
				r.match_flag = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic send_item(input stl_req_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= it;
		do @(posedge clk); while (!req_ch.ready);
		if (it.func == FUNC_LOAD) begin
			key_tab[it.entry_index] = it.key;
			pay_tab[it.entry_index] = it.payload;
			pv_tab[it.entry_index] = it.payload_valid;
			loads_sent++;
		end else begin
			lookups_due.push_back(predict_lookup(it));
			lookups_sent++;
		end
	endtask

	task automatic load_entry(input int idx, input logic signed [KEY_W-1:0] k,
			input logic signed [KEY_W-1:0] p, input logic pv);
		stl_req_t it;
		it.func = FUNC_LOAD;
		it.entry_index = IDX_IN_W'(idx);
		it.key = k;
		it.key_valid = 1'($urandom_range(0, 1));
		it.payload = p;
		it.payload_valid = pv;
		send_item(it);
	endtask

	task automatic probe_key(input logic signed [KEY_W-1:0] k, input logic kv);
		stl_req_t it;
		it.func = FUNC_PROBE;
		it.entry_index = IDX_IN_W'($urandom_range(0, STL_DEPTH - 1));
		it.key = k;
		it.key_valid = kv;
		it.payload = rand64();
		it.payload_valid = 1'($urandom_range(0, 1));
		send_item(it);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_wdata <= data;
		cfg_we <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_TABLE_COUNT: tab_count = data;
			REG_FETCH_MODE:  fetch_on = data[0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every lookup has answered, then lets a trailing load settle.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (lookups_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Loads entries 0..n-1 with keys in ascending order unless asked otherwise.
	task automatic load_table(input int n, input fill_style_t style);
		logic signed [KEY_W-1:0] kbuf [STL_DEPTH];
		logic signed [KEY_W-1:0] base, t;
		int                      i, j;
		base = rand64();
		for (i = 0; i < n; i++)
			kbuf[i] = (style == FILL_CLUSTER) ? base + $urandom_range(0, n) : rand64();
		if (style != FILL_UNSORTED) begin
			for (i = 1; i < n; i++) begin
				t = kbuf[i];
				j = i - 1;
				while (j >= 0 && kbuf[j] > t) begin
					kbuf[j+1] = kbuf[j];
					j--;
				end
				kbuf[j+1] = t;
			end
		end
		for (i = 0; i < n; i++)
			load_entry(i, kbuf[i], rand64(), 1'($urandom_range(0, 1)));
	endtask

	function automatic logic signed [KEY_W-1:0] pick_probe_key(input int n);
		int unsigned r;
		int          i;
		if (n < 1)
			n = 1;
		r = $urandom_range(0, 99);
		i = $urandom_range(0, n - 1);
		if (r < 45)
			return key_tab[i];
		else if (r < 60)
			return $urandom_range(0, 1) ? key_tab[i] + 1 : key_tab[i] - 1;
		else if (r < 70)
			return key_tab[0] - 1 - $urandom_range(0, 3);
		else if (r < 78)
			return key_tab[n-1] + 1 + $urandom_range(0, 3);
		else if (r < 93)
			return rand64();
		else
			return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
	endfunction

	// Response side: random stalls, plus long holds on request.
	initial begin
		int stall_left, hold_left, holds_done;
		rsp_ch.ready = 1'b0;
		stall_left = 0;
		hold_left = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				holds_done = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!no_gaps && $urandom_range(0, 99) < 25) begin
				stall_left = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 2)
					: $urandom_range(4, 39);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		stl_rsp_t want, got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.data;
			if (lookups_due.size() == 0) begin
				$error("lookup result with no lookup pending: match_flag %0d, lookup_value %0d",
					got.match_flag, $signed(got.lookup_value));
				mismatches++;
			end else begin
				want = lookups_due.pop_front();
				lookups_checked++;
				if (got.match_flag !== want.match_flag) begin
					$error("match_flag: expected %0d, actual %0d",
						want.match_flag, got.match_flag);
					mismatches++;
				end
				if (got.lookup_value !== want.lookup_value) begin
					$error("lookup_value: expected %0d, actual %0d",
						$signed(want.lookup_value), $signed(got.lookup_value));
					mismatches++;
				end
			end
		end
	end

	// With no entries in use every probe misses without a search.
	task automatic test_empty_table();
		probe_key(KEY_MIN, 1'b1);
		probe_key(64'sd0, 1'b1);
		probe_key(KEY_MAX, 1'b0);
		wait_drained();
		write_reg(REG_FETCH_MODE, 11'h001);
		probe_key(KEY_MAX, 1'b1);
		probe_key(rand64(), 1'b1);
		wait_drained();
	endtask

	// Writes every slot, then probes the full-depth table.
	task automatic test_full_table();
		load_table(STL_DEPTH, FILL_WIDE);
		load_entry(0, KEY_MIN, rand64(), 1'b1);
		load_entry(STL_DEPTH - 1, KEY_MAX, rand64(), 1'b1);
		wait_drained();
		write_reg(REG_TABLE_COUNT, CFG_DATA_W'(STL_DEPTH));
		probe_key(KEY_MIN, 1'b1);
		probe_key(KEY_MAX, 1'b1);
		probe_key(key_tab[512], 1'b1);
		probe_key(key_tab[511] + 1, 1'b1);
		probe_key(KEY_MAX, 1'b0);
		wait_drained();
		// Counts above the depth are clamped to it.
		write_reg(REG_TABLE_COUNT, 11'h7FF);
		write_reg(REG_FETCH_MODE, 11'h000);
		probe_key(KEY_MAX, 1'b1);
		probe_key(key_tab[700], 1'b1);
		wait_drained();
		write_reg(REG_TABLE_COUNT, CFG_DATA_W'(STL_DEPTH + 1));
		probe_key(key_tab[STL_DEPTH-1], 1'b1);
		wait_drained();
	endtask

	// Bounds, duplicate keys, single entry and an unsorted table.
	task automatic test_directed_cases();
		load_entry(0, KEY_MIN, 64'sd11, 1'b1);
		load_entry(1, -64'sd5, KEY_MIN, 1'b0);
		load_entry(2, 64'sd3, 64'sd33, 1'b0);
		load_entry(3, 64'sd3, 64'sd44, 1'b1);
		load_entry(4, 64'sd3, 64'sd55, 1'b1);
		load_entry(5, 64'sd10, KEY_MAX, 1'b1);
		load_entry(6, KEY_MAX, -64'sd1, 1'b1);
		wait_drained();
		write_reg(REG_TABLE_COUNT, 11'd7);
		write_reg(REG_FETCH_MODE, 11'h001);
		probe_key(KEY_MIN, 1'b1);
		probe_key(KEY_MAX, 1'b1);
		probe_key(64'sd3, 1'b1);
		probe_key(-64'sd5, 1'b1);
		probe_key(64'sd4, 1'b1);
		probe_key(64'sd3, 1'b0);
		probe_key(64'sd10, 1'b1);
		wait_drained();
		write_reg(REG_TABLE_COUNT, 11'd6);
		// Only bit 0 of the mode write counts.
		write_reg(REG_FETCH_MODE, 11'h7FE);
		probe_key(KEY_MAX, 1'b1);
		probe_key(64'sd11, 1'b1);
		probe_key(64'sd3, 1'b1);
		probe_key(64'sd4, 1'b1);
		wait_drained();
		write_reg(REG_TABLE_COUNT, 11'd1);
		write_reg(REG_FETCH_MODE, 11'h001);
		probe_key(KEY_MIN, 1'b1);
		probe_key(-64'sd5, 1'b1);
		wait_drained();
		load_entry(0, 64'sd1, 64'sd101, 1'b1);
		load_entry(1, 64'sd9, 64'sd109, 1'b1);
		load_entry(2, 64'sd5, 64'sd105, 1'b1);
		wait_drained();
		write_reg(REG_TABLE_COUNT, 11'd3);
		probe_key(64'sd5, 1'b1);
		probe_key(64'sd1, 1'b1);
		wait_drained();
	endtask

	task automatic test_spare_registers();
		write_reg(REG_SPARE_2, 11'h000);
		write_reg(REG_SPARE_3, 11'h7FF);
		probe_key(64'sd1, 1'b1);
		probe_key(64'sd5, 1'b1);
		wait_drained();
	endtask

	// The response side stops for a long stretch while probes keep coming.
	task automatic test_backpressure();
		int i;
		load_table(8, FILL_WIDE);
		wait_drained();
		write_reg(REG_TABLE_COUNT, 11'd8);
		write_reg(REG_FETCH_MODE, 11'h001);
		hold_requests++;
		no_gaps = 1'b1;
		for (i = 0; i < 40; i++)
			probe_key(pick_probe_key(8), 1'b1);
		no_gaps = 1'b0;
		wait_drained();
	endtask

	task automatic test_random_lookups();
		int          start_items, phase, n, m, i;
		int unsigned r;
		fill_style_t style;
		logic [CFG_DATA_W-1:0] cnt;
		start_items = loads_sent + lookups_sent;
		phase = 0;
		while (loads_sent + lookups_sent - start_items < RANDOM_ITEMS) begin
			phase++;
			if (phase == 6)
				n = $urandom_range(200, 400);
			else if ($urandom_range(0, 3) == 0)
				n = $urandom_range(1, 64);
			else
				n = $urandom_range(1, 16);
			r = $urandom_range(0, 19);
			style = (r < 2) ? FILL_UNSORTED : (r < 7) ? FILL_CLUSTER : FILL_WIDE;
			no_gaps = ($urandom_range(0, 4) == 0);
			load_table(n, style);
			wait_drained();
			r = $urandom_range(0, 99);
			if (r < 80)
				cnt = CFG_DATA_W'(n);
			else if (r < 88)
				cnt = CFG_DATA_W'($urandom_range(0, n));
			else if (r < 92)
				cnt = '0;
			else if (r < 96)
				cnt = CFG_DATA_W'(STL_DEPTH);
			else
				cnt = CFG_DATA_W'($urandom_range(STL_DEPTH + 1, 2047));
			write_reg(REG_TABLE_COUNT, cnt);
			write_reg(REG_FETCH_MODE, {10'($urandom_range(0, 1023)),
				1'($urandom_range(0, 1))});
			m = $urandom_range(8, 30);
			for (i = 0; i < m; i++) begin
				// A stray load now and then; every slot already holds data.
				if ($urandom_range(0, 11) == 0)
					load_entry($urandom_range(0, STL_DEPTH - 1), rand64(), rand64(),
						1'($urandom_range(0, 1)));
				else
					probe_key(pick_probe_key(n), $urandom_range(0, 9) != 0);
			end
			wait_drained();
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		tab_count = '0;
		fetch_on = 1'b0;
		no_gaps = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_empty_table();
		test_full_table();
		test_directed_cases();
		test_spare_registers();
		test_backpressure();
		test_random_lookups();

		wait_drained();
		$display("Sent %0d loads and %0d lookups; %0d lookup results were checked.",
			loads_sent, lookups_sent, lookups_checked);
		$display("Tables ran from empty to full depth, sorted, clustered and unsorted, in both modes.");
		if (mismatches == 0 && lookups_due.size() == 0) begin
			$display("sorted_table_key_lookup test passed");
		end else begin
			$display("sorted_table_key_lookup test failed");
		end
		$finish;
	end

endmodule
